@@ hw/rtl/pett_pkg.sv @@
// Shared constants, types and register indexes for the periodic event tick timer.
package pett_pkg;

  localparam int CHANNELS    = 2;
  localparam int COUNT_WIDTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int INDEX_WIDTH = 3;
  localparam int MASK_WIDTH  = 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [DATA_WIDTH-1:0]  data_t;

  localparam data_t PERIOD_A_RESET = data_t'(500);
  localparam data_t PERIOD_B_RESET = data_t'(50);
  localparam data_t REPEAT_RESET   = '1;
  localparam logic [MASK_WIDTH-1:0] ENABLE_RESET = '1;

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_PERIOD_A = 3'd0,
    REG_PERIOD_B = 3'd1,
    REG_REPEAT_A = 3'd2,
    REG_REPEAT_B = 3'd3,
    REG_ENABLE   = 3'd4
  } reg_index_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  typedef struct packed {
    logic  tick;
    logic  rep_load;
    data_t rep_value;
  } chan_ctrl_t;

endpackage

@@ hw/rtl/pett_channel.sv @@
// One periodic channel: tick counter, period match and repeat bookkeeping.
module pett_channel (
  input  logic                clk,
  input  logic                rst,
  input  pett_pkg::chan_ctrl_t ctrl,
  input  pett_pkg::data_t     period,
  output logic                fire
);

  pett_pkg::count_t tick_count;
  pett_pkg::count_t tick_count_next;
  pett_pkg::data_t  repeats_left;
  pett_pkg::data_t  repeats_left_next;
  pett_pkg::count_t cnt_inc;
  logic             match;
  logic             has_repeat;

  assign cnt_inc    = tick_count + pett_pkg::count_t'(1);
  // a zero period never matches
  assign match      = (period != '0) &&
                      (pett_pkg::data_t'(cnt_inc) == period);
  assign has_repeat = repeats_left[pett_pkg::DATA_WIDTH-1] || (repeats_left != '0);
  assign fire       = ctrl.tick && match && has_repeat;

  always_comb begin
    tick_count_next   = tick_count;
    repeats_left_next = repeats_left;
    if (ctrl.tick) begin
      tick_count_next = match ? '0 : cnt_inc;
      if (match && !repeats_left[pett_pkg::DATA_WIDTH-1] && (repeats_left != '0)) begin
        repeats_left_next = repeats_left - pett_pkg::data_t'(1);
      end
    end
    if (ctrl.rep_load) begin
      repeats_left_next = ctrl.rep_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      repeats_left <= pett_pkg::REPEAT_RESET;
    end else begin
      tick_count   <= tick_count_next;
      repeats_left <= repeats_left_next;
    end
  end

endmodule

@@ hw/rtl/periodic_event_tick_timer.sv @@
// Top level of the periodic event tick timer with delay countdown.
//
// Input channel (in_valid/in_ready): req_type 0 is one elapsed tick, req_type 1
// loads delay_load into the delay down-counter. Every beat yields one result
// beat on the output channel (out_valid/out_ready): fire_mask has a bit per
// channel that fired on this tick, delay_pending and delay_left report the
// delay counter after the item.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): periods, repeat
// counts (a write also reloads the remaining repeats) and channel enables.
// Each input beat's result is registered; with no stall, one item per cycle is
// sustained. The result register frees as its beat is taken, so a new input
// is taken in the same cycle the output is read; while the receiver stalls
// with a result held, in_ready is low.
// Synchronous reset clears counters, restores the register defaults
// (periods 500 and 50, repeat forever, both channels enabled) and drops
// any pending result. No beat is taken while reset is high.
module periodic_event_tick_timer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [pett_pkg::DATA_WIDTH-1:0]      delay_load,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pett_pkg::MASK_WIDTH-1:0]      fire_mask,
  output logic                                 delay_pending,
  output logic [pett_pkg::DATA_WIDTH-1:0]      delay_left,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pett_pkg::INDEX_WIDTH-1:0]     cfg_index,
  input  logic [pett_pkg::DATA_WIDTH-1:0]      cfg_data
);

  pett_pkg::data_t                  period [2];
  logic [pett_pkg::MASK_WIDTH-1:0]  channel_enable;
  pett_pkg::count_t                 delay_count;
  pett_pkg::count_t                 delay_count_next;
  logic                             in_accept;
  logic                             cfg_accept;
  logic                             tick;
  logic [pett_pkg::MASK_WIDTH-1:0]  fire;
  pett_pkg::chan_ctrl_t             ctrl [2];

  assign in_ready   = !rst && (!out_valid || out_ready);
  assign cfg_ready  = !rst;
  assign in_accept  = in_valid && in_ready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign tick       = in_accept && (pett_pkg::req_t'(req_type) == pett_pkg::REQ_TICK);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period[0]      <= pett_pkg::PERIOD_A_RESET;
      period[1]      <= pett_pkg::PERIOD_B_RESET;
      channel_enable <= pett_pkg::ENABLE_RESET;
    end else if (cfg_accept) begin
      case (pett_pkg::reg_index_t'(cfg_index))
        pett_pkg::REG_PERIOD_A: period[0] <= cfg_data;
        pett_pkg::REG_PERIOD_B: period[1] <= cfg_data;
        pett_pkg::REG_ENABLE:   channel_enable <= cfg_data[pett_pkg::MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl[0].tick      = tick && channel_enable[0];
    ctrl[0].rep_load  = cfg_accept &&
                        (pett_pkg::reg_index_t'(cfg_index) == pett_pkg::REG_REPEAT_A);
    ctrl[0].rep_value = cfg_data;
    ctrl[1].tick      = tick && channel_enable[1];
    ctrl[1].rep_load  = cfg_accept &&
                        (pett_pkg::reg_index_t'(cfg_index) == pett_pkg::REG_REPEAT_B);
    ctrl[1].rep_value = cfg_data;
  end

  for (genvar c = 0; c < pett_pkg::MASK_WIDTH; c++) begin : g_chan
    if (c < pett_pkg::CHANNELS) begin : g_on
      pett_channel u_chan (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl[c]),
        .period (period[c]),
        .fire   (fire[c])
      );
    end else begin : g_off
      assign fire[c] = 1'b0;
    end
  end

  // delay down-counter
  always_comb begin
    delay_count_next = delay_count;
    if (in_accept) begin
      if (pett_pkg::req_t'(req_type) == pett_pkg::REQ_LOAD) begin
        delay_count_next = delay_load[pett_pkg::COUNT_WIDTH-1:0];
      end else if (delay_count != '0) begin
        delay_count_next = delay_count - pett_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      delay_count <= delay_count_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fire_mask     <= fire;
      delay_pending <= (delay_count_next != '0);
      delay_left    <= pett_pkg::data_t'(delay_count_next);
    end
  end

endmodule

@@ hw/rtl/pett_checker.sv @@
// Port-level checker for the periodic event tick timer, bound to the top level.
module pett_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             req_type,
  input logic [pett_pkg::DATA_WIDTH-1:0]  delay_load,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pett_pkg::MASK_WIDTH-1:0]  fire_mask,
  input logic                             delay_pending,
  input logic [pett_pkg::DATA_WIDTH-1:0]  delay_left
);

  logic load_beat;
  assign load_beat = in_valid && in_ready && req_type;

  a_result_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input beat not followed by a result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fire_mask) && $stable(delay_left))
    else $error("stalled result changed");

  a_load_no_fire: assert property (@(posedge clk) disable iff (rst)
    load_beat |=> fire_mask == '0)
    else $error("load beat reported a firing");

  a_load_value: assert property (@(posedge clk) disable iff (rst)
    load_beat |=> delay_left ==
      pett_pkg::data_t'($past(delay_load[pett_pkg::COUNT_WIDTH-1:0]))
      && delay_pending == (delay_left != '0))
    else $error("delay load not reflected in result");

endmodule

bind periodic_event_tick_timer pett_checker u_pett_checker (.*);
